[rtl/psd_pkg.sv]
// Package: shared types and constants for the register dump stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

   // Header layout
   localparam logic [3:0] HdrRatePos   = 4'd5;
   localparam logic [3:0] HdrLastPos   = 4'd15;
   localparam logic [7:0] HdrMagicP    = 8'h50;
   localparam logic [7:0] HdrMagicS    = 8'h53;
   localparam logic [7:0] HdrMagicG    = 8'h47;
   localparam logic [7:0] HdrMagicEof  = 8'h1A;
   localparam logic [7:0] DefaultRate  = 8'd50;

   // Body marker bytes
   localparam logic [7:0] MarkFrame    = 8'hFF;
   localparam logic [7:0] MarkDelay    = 8'hFE;
   localparam logic [7:0] MarkEnd      = 8'hFD;

   // Depth of the queue between front and back
   localparam int unsigned QueueDepth  = 2;

   // Decoder phase
   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_BODY   = 3'd1,
      PH_VALUE  = 3'd2,
      PH_DELAY  = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   // Result event codes
   typedef enum logic [2:0] {
      EV_WRITE   = 3'd0,
      EV_FRAME   = 3'd1,
      EV_END     = 3'd2,
      EV_HDR_OK  = 3'd3,
      EV_HDR_BAD = 3'd4
   } event_kind_type;

   // Operations queued from front to back
   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_FRAME   = 3'd1,
      OP_DELAY   = 3'd2,
      OP_END     = 3'd3,
      OP_HDR_OK  = 3'd4,
      OP_HDR_BAD = 3'd5
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  arg_a;   // held register or header rate byte
      logic [7:0]  arg_b;   // value byte or delay count
   } psd_op_type;

endpackage

`default_nettype wire

[rtl/psd_ifs.sv]
// Interfaces: request byte channel and result channel.
`timescale 1ns / 1ps
`default_nettype none

interface psd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface psd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [7:0] reg_index;
   logic [7:0] reg_value;
   logic [9:0] frame_count;
   logic [7:0] frame_rate;

   modport source (output valid, output event_kind, output reg_index, output reg_value,
                   output frame_count, output frame_rate, input ready);
   modport sink   (input valid, input event_kind, input reg_index, input reg_value,
                   input frame_count, input frame_rate, output ready);
endinterface

`default_nettype wire

[rtl/psd_front.sv]
// Front end: accepts request bytes, tracks header and body phase, queues operations.
`timescale 1ns / 1ps
`default_nettype none

module psd_front (
   input  wire logic           clock,
   input  wire logic           reset,
   psd_req_if.sink             req_if,
   input  wire logic           queue_full,
   output logic                push_valid,
   output psd_pkg::psd_op_type push_op
);
   import psd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] header_pos_ff, header_pos_in;
   logic       header_good_ff, header_good_in;
   logic [7:0] rate_seen_ff, rate_seen_in;
   logic [7:0] held_reg_ff, held_reg_in;

   logic       accept;
   logic [7:0] data_byte;
   logic       magic_miss;

   // Take a request whenever the queue has room
   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign data_byte    = req_if.data_byte;

   // Compare header magic bytes at their positions
   always_comb begin
      case (header_pos_ff)
         4'd0:    magic_miss = (data_byte != HdrMagicP);
         4'd1:    magic_miss = (data_byte != HdrMagicS);
         4'd2:    magic_miss = (data_byte != HdrMagicG);
         4'd3:    magic_miss = (data_byte != HdrMagicEof);
         default: magic_miss = 1'b0;
      endcase
   end

   // Hold phase and header state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         header_pos_ff  <= '0;
         header_good_ff <= 1'b1;
         rate_seen_ff   <= '0;
         held_reg_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         header_pos_ff  <= header_pos_in;
         header_good_ff <= header_good_in;
         rate_seen_ff   <= rate_seen_in;
         held_reg_ff    <= held_reg_in;
      end
   end

   // Classify the accepted byte and advance the phase
   always_comb begin
      phase_in       = phase_ff;
      header_pos_in  = header_pos_ff;
      header_good_in = header_good_ff;
      rate_seen_in   = rate_seen_ff;
      held_reg_in    = held_reg_ff;
      push_valid     = 1'b0;
      push_op        = '{kind: OP_WRITE, arg_a: '0, arg_b: '0};
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               header_good_in = header_good_ff && !magic_miss;
               if (header_pos_ff == HdrRatePos) begin
                  rate_seen_in = data_byte;
               end
               if (header_pos_ff != HdrLastPos) begin
                  header_pos_in = header_pos_ff + 4'd1;
               end else begin
                  header_pos_in = '0;
                  push_valid    = 1'b1;
                  push_op.arg_a = rate_seen_ff;
                  if (header_good_in) begin
                     push_op.kind = OP_HDR_OK;
                     phase_in     = PH_BODY;
                  end else begin
                     push_op.kind = OP_HDR_BAD;
                     phase_in     = PH_STOP;
                  end
               end
            end
            PH_BODY: begin
               case (data_byte)
                  MarkFrame: begin
                     push_valid   = 1'b1;
                     push_op.kind = OP_FRAME;
                  end
                  MarkDelay: begin
                     phase_in = PH_DELAY;
                  end
                  MarkEnd: begin
                     push_valid   = 1'b1;
                     push_op.kind = OP_END;
                     phase_in     = PH_STOP;
                  end
                  default: begin
                     held_reg_in = data_byte;
                     phase_in    = PH_VALUE;
                  end
               endcase
            end
            PH_VALUE: begin
               push_valid    = 1'b1;
               push_op.kind  = OP_WRITE;
               push_op.arg_a = held_reg_ff;
               push_op.arg_b = data_byte;
               phase_in      = PH_BODY;
            end
            PH_DELAY: begin
               push_valid    = 1'b1;
               push_op.kind  = OP_DELAY;
               push_op.arg_b = data_byte;
               phase_in      = PH_BODY;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // A stopped decoder never queues anything
   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STOP |-> !push_valid)
      else $error("front queued an operation while stopped");

   // Header position only moves during the header phase
   a_hdr_pos_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEADER |-> header_pos_ff == 4'd0)
      else $error("header position nonzero outside header phase");

endmodule

`default_nettype wire

[rtl/psd_queue.sv]
// Short queue of decoded operations between front and back.
`timescale 1ns / 1ps
`default_nettype none

module psd_queue #(
   parameter int unsigned DEPTH = psd_pkg::QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire psd_pkg::psd_op_type push_op,
   output logic                     full,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output psd_pkg::psd_op_type      pop_op
);
   import psd_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   psd_op_type       entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   // Advance pointers with wrap and track occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CntW'(do_push) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed operation
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   // The front only pushes when there is room
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("push into a full queue");

   // An empty or full queue has equal read and write pointers
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CntW'(DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

[rtl/psd_back.sv]
// Back end: turns queued operations into results held in an output register.
`timescale 1ns / 1ps
`default_nettype none

module psd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  wire psd_pkg::psd_op_type pop_op,
   output logic                     pop_ready,
   psd_rsp_if.source                rsp_if
);
   import psd_pkg::*;

   logic           rsp_valid_ff, rsp_valid_in;
   event_kind_type kind_ff, kind_in;
   logic [7:0]     index_ff, index_in;
   logic [7:0]     value_ff, value_in;
   logic [9:0]     count_ff, count_in;
   logic [7:0]     rate_ff, rate_in;
   logic           load;

   // Refill the output register when it is empty or being taken
   assign pop_ready = !rsp_valid_ff || rsp_if.ready;
   assign load      = pop_valid && pop_ready;

   // Format the result fields
   always_comb begin
      kind_in  = EV_WRITE;
      index_in = '0;
      value_in = '0;
      count_in = '0;
      rate_in  = '0;
      case (pop_op.kind)
         OP_WRITE: begin
            kind_in  = EV_WRITE;
            index_in = pop_op.arg_a;
            value_in = pop_op.arg_b;
         end
         OP_FRAME: begin
            kind_in  = EV_FRAME;
            count_in = 10'd1;
         end
         OP_DELAY: begin
            kind_in  = EV_FRAME;
            count_in = (pop_op.arg_b == '0) ? 10'd1 : {pop_op.arg_b, 2'b00};
         end
         OP_END: begin
            kind_in = EV_END;
         end
         OP_HDR_OK: begin
            kind_in = EV_HDR_OK;
            rate_in = (pop_op.arg_a == '0) ? DefaultRate : pop_op.arg_a;
         end
         OP_HDR_BAD: begin
            kind_in = EV_HDR_BAD;
            rate_in = (pop_op.arg_a == '0) ? DefaultRate : pop_op.arg_a;
         end
         default: begin
            kind_in = EV_WRITE;
         end
      endcase
   end

   // Output valid: set on load, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         index_ff <= index_in;
         value_ff <= value_in;
         count_ff <= count_in;
         rate_ff  <= rate_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_kind  = kind_ff;
   assign rsp_if.reg_index   = index_ff;
   assign rsp_if.reg_value   = value_ff;
   assign rsp_if.frame_count = count_ff;
   assign rsp_if.frame_rate  = rate_ff;

   // A frame end always covers at least one frame
   a_frame_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == EV_FRAME |-> count_ff != 10'd0)
      else $error("frame end with zero frame count");

   // A loaded operation shows up as a result in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded operation did not produce a result");

endmodule

`default_nettype wire

[rtl/psg_stream_decoder_unit.sv]
// Top level: sound chip register dump stream decoder.
//
// Usage: feed the dump file one byte per request on req_if (valid/ready,
// payload data_byte). The first 16 bytes are the header; on the 16th the
// block returns "header ok" or "header bad" with the frame rate (50 when
// the rate byte is zero). Body bytes give register writes, frame ends
// (frame_count 1, or 4n for delay byte n > 0) and an end-of-stream event.
// After a bad header or end of stream all bytes are accepted and dropped.
// Results leave on rsp_if (valid/ready) with fields event_kind, reg_index,
// reg_value, frame_count and frame_rate; unused fields read zero.
// A result is registered in the queue, then in the back's output register,
// before it leaves on rsp_if. Throughput: one byte per cycle while the
// queue has room, set by the front phase logic.
// When the receiver stalls, the queue of QUEUE_DEPTH operations fills and
// req_if.ready drops until results are taken again.
// Reset (synchronous, active high) returns the decoder to the header phase
// and empties the queue and output register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module psg_stream_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = psd_pkg::QueueDepth
) (
   input  wire logic clock,
   input  wire logic reset,
   psd_req_if.sink   req_if,
   psd_rsp_if.source rsp_if
);
   import psd_pkg::*;

   logic       queue_full;
   logic       push_valid;
   psd_op_type push_op;
   logic       pop_valid;
   logic       pop_ready;
   psd_op_type pop_op;

   // Classify incoming bytes
   psd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_op    (push_op)
   );

   // Decouple front and back
   psd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Produce results
   psd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
